FILE: design/chol_pkg.sv
// shared types and constants for the cholesky factorization block
package chol_pkg;

  localparam int DATA_W = 32;
  localparam int DIM_W  = 4;
  localparam int ACC_W  = 64;

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // start request and operands handed to the arithmetic unit
  typedef struct packed {
    logic                    sqrt_go;
    logic                    div_go;
    logic signed [ACC_W-1:0] num;
    logic [DATA_W-1:0]       dvs;
  } au_req_t;

  // status returned by the arithmetic unit
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] res;
  } au_rsp_t;

endpackage

FILE: design/chol_au.sv
// iterative square root and divider, one result bit per cycle
module chol_au #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  chol_pkg::au_req_t req,
  output chol_pkg::au_rsp_t rsp
);
  import chol_pkg::*;

  localparam int CNT_W = 7;
  localparam logic [ACC_W-1:0] SQ_LIM = (64'd1 << (62 - FRAC_BITS)) - 64'd1;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ACC_W + FRAC_BITS - 1);

  typedef enum logic [2:0] {S_IDLE, S_SQRT, S_DIV, S_FIN, S_DONE} st_t;

  st_t               st_r;
  logic [ACC_W-1:0]  v_r;
  logic [ACC_W-1:0]  res_r;
  logic [ACC_W-1:0]  bit_r;
  logic [ACC_W-1:0]  dvd_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] dv_r;
  logic [DATA_W-1:0] q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              neg_r;
  logic              ovf_r;
  logic [DATA_W-1:0] out_r;

  logic [ACC_W-1:0]  sq_sat;
  logic [ACC_W-1:0]  sq_in;
  logic [ACC_W-1:0]  mag;
  logic [ACC_W-1:0]  rb;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_df;
  logic              q_bit;

  always_comb begin
    sq_sat = ($unsigned(req.num) > SQ_LIM) ? SQ_LIM : $unsigned(req.num);
    sq_in  = sq_sat << FRAC_BITS;
    mag    = req.num[ACC_W-1] ? (~req.num + 64'd1) : req.num;
    rb     = res_r + bit_r;
    rem_sh = {rem_r, dvd_r[ACC_W-1]};
    rem_df = rem_sh - {1'b0, dv_r};
    q_bit  = (rem_sh >= {1'b0, dv_r});
  end

  // sequencer for both operations; division is restoring over the dividend bits then
  // the fraction bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (req.sqrt_go) begin
            v_r   <= sq_in;
            res_r <= '0;
            bit_r <= 64'd1 << 62;
            st_r  <= S_SQRT;
          end else if (req.div_go) begin
            neg_r <= req.num[ACC_W-1];
            dvd_r <= mag;
            rem_r <= '0;
            q_r   <= '0;
            dv_r  <= req.dvs;
            cnt_r <= '0;
            ovf_r <= 1'b0;
            st_r  <= S_DIV;
          end
        end
        S_SQRT: begin
          if (bit_r == '0) begin
            out_r <= res_r[DATA_W-1:0];
            st_r  <= S_DONE;
          end else begin
            if (v_r >= rb) begin
              v_r   <= v_r - rb;
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        S_DIV: begin
          // a set quotient bit leaving the top means the result saturates
          if (q_r[DATA_W-1]) ovf_r <= 1'b1;
          q_r   <= {q_r[DATA_W-2:0], q_bit};
          rem_r <= q_bit ? rem_df[DATA_W-1:0] : rem_sh[DATA_W-1:0];
          dvd_r <= {dvd_r[ACC_W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_LAST) st_r <= S_FIN;
        end
        S_FIN: begin
          // range check and sign
          if (ovf_r || q_r[DATA_W-1])
            out_r <= neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
          else
            out_r <= neg_r ? (~q_r + 1'b1) : q_r;
          st_r <= S_DONE;
        end
        S_DONE: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = (st_r == S_DONE);
  assign rsp.res  = out_r;
endmodule

FILE: design/cholesky_decomposition_top.sv
// top level: matrix store, factorization sequencer and output stream
//
//  channel | ports                          | payload
//  --------+--------------------------------+-------------------------------------------
//  cfg     | cfg_valid cfg_ready cfg_data   | dimension [3:0]
//  in      | in_tvalid in_tready in_tdata   | element_value [31:0]
//  out     | out_tvalid out_tready out_tdata| result_value [31:0], tlast is_last,
//          | out_tlast out_tuser            | tuser not_positive_definite
//
// loading accepts one beat per cycle while in_tready is high. after the last beat of a
// matrix the block factors it: for each entry of the lower triangle a dot product over
// the earlier columns, then a square root on the diagonal or a division below it. it
// then emits n*n beats. in_tready is low from the last load beat until the final
// output beat is taken, and while cfg_valid is high. cfg_ready is high only while
// loading. out_tready may stall at any time.
// reset (synchronous, rst_n low) clears the load count and error flag and sets the dimension to 8.
module cholesky_decomposition_top #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [chol_pkg::DIM_W-1:0]  cfg_data,   // dimension
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [chol_pkg::DATA_W-1:0] in_tdata,   // element_value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [chol_pkg::DATA_W-1:0] out_tdata,  // result_value
  output logic                        out_tlast,  // is_last
  output logic                        out_tuser   // not_positive_definite
);
  import chol_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW    = 7;

  typedef enum logic [3:0] {
    S_LOAD, S_PAIR, S_DOT_A, S_DOT_B, S_DOT_M, S_DOT_S, S_ELEM_RD, S_NUM,
    S_DECIDE, S_AU, S_NEXT, S_EMIT_RD, S_EMIT_LD, S_EMIT
  } st_t;

  st_t              st_r;
  logic [DIM_W-1:0] dim_r;
  logic [CW-1:0]    cnt_r;
  logic             err_r;
  logic [IW:0]      n_r;
  logic [IW-1:0]    i_r, j_r, k_r;
  acc_t             sum_r, num_r;
  elem_t            a_r;
  acc_t             prod_r;
  elem_t            mem [DEPTH];
  elem_t            rd_r;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    e_r;
  logic [CW-1:0]    nn_r;
  logic             ov_r, ol_r, ou_r;
  elem_t            od_r;
  au_req_t          req;
  au_rsp_t          rsp;

  logic [IW:0]   n_eff;
  logic [CW-1:0] nn_eff;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  elem_t         wr_data;
  acc_t          rnd;
  logic          zero_ent;

  chol_au #(.FRAC_BITS(FRAC_BITS)) u_au (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  // effective dimension, clamped
  always_comb begin
    if (dim_r == '0) n_eff = (IW+1)'(1);
    else if (32'(dim_r) > MAX_DIM) n_eff = (IW+1)'(MAX_DIM);
    else n_eff = (IW+1)'(dim_r);
    nn_eff = CW'(n_eff) * CW'(n_eff);
  end

  function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                         input logic [IW:0] n);
    logic [CW-1:0] t;
    t = CW'(r) * CW'(n) + CW'(c);
    return t[AW-1:0];
  endfunction

  // rounded product, ties toward plus infinity
  assign rnd = (prod_r + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  // non-positive radicand on the diagonal, or zero column diagonal below it
  assign zero_ent = (i_r == j_r) ? (num_r <= 0) : (rd_r <= 0);

  assign cfg_ready = (st_r == S_LOAD);
  assign in_tready = (st_r == S_LOAD) && !cfg_valid;

  // memory read address by phase
  always_comb begin
    unique case (st_r)
      S_DOT_A:   rd_addr = addr(i_r, k_r, n_r);
      S_DOT_B:   rd_addr = addr(j_r, k_r, n_r);
      S_NUM:     rd_addr = addr(j_r, j_r, n_r);
      S_EMIT_RD: rd_addr = e_r;
      default:   rd_addr = addr(i_r, j_r, n_r);
    endcase
  end

  // store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r[AW-1:0];
    wr_data = in_tdata;
    unique case (st_r)
      S_LOAD: begin
        wr_en = in_tvalid && in_tready && (32'(cnt_r) < DEPTH);
      end
      S_DECIDE: begin
        wr_en   = zero_ent;
        wr_addr = addr(i_r, j_r, n_r);
        wr_data = '0;
      end
      S_AU: begin
        wr_en   = rsp.done;
        wr_addr = addr(i_r, j_r, n_r);
        wr_data = rsp.res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  // arithmetic unit requests
  always_comb begin
    req.sqrt_go = (st_r == S_DECIDE) && (i_r == j_r) && !zero_ent;
    req.div_go  = (st_r == S_DECIDE) && (i_r != j_r) && !zero_ent;
    req.num     = num_r;
    req.dvs     = rd_r;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_LOAD;
      dim_r <= DIM_W'(8);
      cnt_r <= '0;
      err_r <= 1'b0;
      ov_r  <= 1'b0;
      ol_r  <= 1'b0;
      ou_r  <= 1'b0;
      od_r  <= '0;
    end else begin
      unique case (st_r)
        S_LOAD: begin
          if (cfg_valid && cfg_ready) dim_r <= cfg_data;
          if (in_tvalid && in_tready) begin
            if (cnt_r + 1'b1 >= nn_eff) begin
              cnt_r <= '0;
              n_r   <= n_eff;
              nn_r  <= nn_eff;
              err_r <= 1'b0;
              i_r   <= '0;
              j_r   <= '0;
              k_r   <= '0;
              sum_r <= '0;
              st_r  <= S_PAIR;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        // dot product over the factored prefixes of rows i and j
        S_PAIR: st_r <= (k_r < j_r) ? S_DOT_A : S_ELEM_RD;
        S_DOT_A: st_r <= S_DOT_B;
        S_DOT_B: begin
          a_r  <= rd_r;
          st_r <= S_DOT_M;
        end
        S_DOT_M: begin
          prod_r <= acc_t'(a_r) * acc_t'(rd_r);
          st_r   <= S_DOT_S;
        end
        S_DOT_S: begin
          sum_r <= sum_r + rnd;
          k_r   <= k_r + 1'b1;
          st_r  <= S_PAIR;
        end
        S_ELEM_RD: st_r <= S_NUM;
        S_NUM: begin
          num_r <= acc_t'(rd_r) - sum_r;
          st_r  <= S_DECIDE;
        end
        // special cases write zero, the rest go to the shared unit
        S_DECIDE: begin
          if (i_r == j_r && zero_ent) err_r <= 1'b1;
          st_r <= zero_ent ? S_NEXT : S_AU;
        end
        S_AU: begin
          if (rsp.done) st_r <= S_NEXT;
        end
        S_NEXT: begin
          k_r   <= '0;
          sum_r <= '0;
          if (j_r < i_r) begin
            j_r  <= j_r + 1'b1;
            st_r <= S_PAIR;
          end else if ({1'b0, i_r} + 1'b1 < n_r) begin
            i_r  <= i_r + 1'b1;
            j_r  <= '0;
            st_r <= S_PAIR;
          end else begin
            e_r  <= '0;
            st_r <= S_EMIT_RD;
          end
        end
        // output beats in row-major order
        S_EMIT_RD: st_r <= S_EMIT_LD;
        S_EMIT_LD: begin
          od_r <= rd_r;
          ov_r <= 1'b1;
          ol_r <= (CW'(e_r) == nn_r - 1'b1);
          ou_r <= err_r;
          st_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_tready) begin
            ov_r <= 1'b0;
            if (ol_r) begin
              st_r <= S_LOAD;
            end else begin
              e_r  <= e_r + 1'b1;
              st_r <= S_EMIT_RD;
            end
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = ou_r;
endmodule

FILE: tb/testbench.sv
// self-checking testbench for the cholesky factorization block
`timescale 1ns / 1ps

module testbench;
  import chol_pkg::*;

  localparam int MAXD = 8;
  localparam int FRACB = 16;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct {
    elem_t value;
    logic  last;
    logic  npd;
  } entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [DIM_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  // shadow state of the block
  elem_t     mat[64];
  int        loaded;
  int        dim_reg;
  entry_t    factored_q[$];
  logic [31:0] elem_q[$];
  int        mismatches;
  int        cycles;
  int        burst_left, gap_left;
  int        hold_left;
  bit        hold_req;

  cholesky_decomposition_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // product of two entries rounded to the fraction width, ties up
  function automatic longint rnd_prod(elem_t a, elem_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return (p + (longint'(1) << (FRACB - 1))) >>> FRACB;
  endfunction

  function automatic elem_t sqrt_fx(longint r);
    logic [63:0] v, res, bitv;
    v = r;
    if (v > ((64'd1 << (62 - FRACB)) - 1)) v = (64'd1 << (62 - FRACB)) - 1;
    v = v << FRACB;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return elem_t'(res[31:0]);
  endfunction

  function automatic elem_t div_fx(longint num, elem_t d);
    logic [63:0] mag, dv, q, rm;
    bit neg;
    neg = num < 0;
    mag = neg ? -num : num;
    dv = {32'd0, d};
    q = mag / dv;
    rm = mag % dv;
    if (q >= 64'h8000_0000) return neg ? elem_t'(32'h8000_0000) : elem_t'(32'h7fff_ffff);
    for (int i = 0; i < FRACB; i++) begin
      rm = rm << 1;
      q = q << 1;
      if (rm >= dv) begin
        rm = rm - dv;
        q[0] = 1'b1;
      end
    end
    if (!neg) return q > 64'h7fff_ffff ? elem_t'(32'h7fff_ffff) : elem_t'(q[31:0]);
    if (q >= 64'h8000_0000) return elem_t'(32'h8000_0000);
    return elem_t'(-q[31:0]);
  endfunction

  function automatic int active_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > MAXD) return MAXD;
    return dim_reg;
  endfunction

  // factor the shadow matrix and queue the expected output beats
  task automatic factor_and_emit(int n);
    longint acc, num;
    bit err;
    entry_t e;
    err = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j <= i; j++) begin
        acc = 0;
        for (int k = 0; k < j; k++) acc += rnd_prod(mat[i*n+k], mat[j*n+k]);
        num = longint'(mat[i*n+j]) - acc;
        if (i == j) begin
          if (num <= 0) begin
            err = 1;
            mat[i*n+i] = 0;
          end else begin
            mat[i*n+i] = sqrt_fx(num);
          end
        end else begin
          mat[i*n+j] = (mat[j*n+j] <= 0) ? elem_t'(0) : div_fx(num, mat[j*n+j]);
        end
      end
    for (int x = 0; x < n*n; x++) begin
      e.value = mat[x];
      e.last = (x == n*n - 1);
      e.npd = err;
      factored_q.push_back(e);
    end
  endtask

  task automatic accept_element(logic [31:0] v);
    int n;
    n = active_dim();
    if (loaded < 64) mat[loaded] = elem_t'(v);
    loaded = (loaded + 1) & 7'h7f;
    if (loaded >= n*n) begin
      loaded = 0;
      factor_and_emit(n);
    end
  endtask

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        accept_element(in_tdata);
        void'(elem_q.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (elem_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= elem_q[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    entry_t e;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (factored_q.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected beat data=%h", out_tdata);
        end else begin
          e = factored_q.pop_front();
          if (out_tdata !== e.value || out_tlast !== e.last || out_tuser !== e.npd) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch: exp %h last %b npd %b, got %h last %b npd %b",
                       e.value, e.last, e.npd, out_tdata, out_tlast, out_tuser);
          end
        end
      end
      if (hold_req) begin
        hold_left <= 6000;
        hold_req <= 1'b0;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (cycles[9]) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_dim(int d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= d[DIM_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dim_reg = d;
  endtask

  task automatic wait_drained();
    while (elem_q.size() > 0 || in_tvalid) @(posedge clk);
    while (factored_q.size() > 0) @(posedge clk);
    repeat (2200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  // push one matrix; spd builds a well-conditioned positive definite one
  task automatic push_matrix(int n, bit spd);
    logic [31:0] m[64];
    for (int i = 0; i < n; i++)
      for (int j = 0; j <= i; j++) begin
        if (spd) begin
          m[i*n+j] = (i == j) ? 32'h0010_0000 + $urandom_range(0, 32'h0010_0000)
                              : $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        end else begin
          m[i*n+j] = rand_elem();
        end
        m[j*n+i] = spd ? m[i*n+j] : rand_elem();
      end
    for (int x = 0; x < n*n; x++) elem_q.push_back(m[x]);
  endtask

  initial begin
    int sent, n;
    loaded = 0;
    dim_reg = 8;
    mismatches = 0;
    cycles = 0;
    burst_left = 0;
    gap_left = 0;
    hold_left = 0;
    hold_req = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 1x1 extremes, zero and negative diagonal, 2x2 cases
    write_dim(1);
    elem_q.push_back(32'h7fff_ffff);
    elem_q.push_back(32'h8000_0000);
    elem_q.push_back(32'h0000_0000);
    elem_q.push_back(32'h0001_0000);
    elem_q.push_back(32'hffff_ffff);
    elem_q.push_back(32'h0000_0001);
    wait_drained();
    write_dim(0);
    elem_q.push_back(32'h0004_0000);
    wait_drained();
    write_dim(2);
    elem_q.push_back(32'h0000_0000); elem_q.push_back(32'h1234_5678);
    elem_q.push_back(32'h0003_0000); elem_q.push_back(32'h0001_0000);
    elem_q.push_back(32'h0000_0001); elem_q.push_back(32'h0);
    elem_q.push_back(32'h7fff_ffff); elem_q.push_back(32'h7fff_ffff);
    wait_drained();
    write_dim(15);
    push_matrix(8, 1);
    // long receiver hold while the sender keeps offering
    hold_req = 1;
    push_matrix(8, 1);
    wait_drained();
    sent = 143;

    // random phases over several dimensions
    while (sent < 230) begin
      n = $urandom_range(1, 8);
      write_dim(n);
      repeat ($urandom_range(1, 3)) begin
        if (sent < 230) begin
          push_matrix(n, $urandom_range(0, 3) != 0);
          sent += n*n;
        end
      end
      // dimension change in the middle of a load
      if (n > 2 && $urandom_range(0, 3) == 0) begin
        elem_q.push_back(rand_elem());
        while (elem_q.size() > 0 || in_tvalid) @(posedge clk);
        write_dim(n - 1);
        push_matrix(n - 1, 1);
        sent += (n - 1) * (n - 1) + 1;
      end
      wait_drained();
    end
    write_dim(8);
    push_matrix(8, 1);
    wait_drained();

    if (mismatches == 0 && factored_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/chol_pkg.sv
design/chol_au.sv
design/cholesky_decomposition_top.sv
tb/testbench.sv
